### rtl/core/fcd_pkg.sv
// Shared types and constants for the FAT chain defragmenter core.
// Used by fcd_link_unit and fat_chain_defragmenter_core; no dependencies.
`default_nettype none

package fcd_pkg;

   // Default configuration of the table
   localparam int TABLE_ENTRIES_DEF        = 4096;
   localparam int FIRST_SEARCH_CLUSTER_DEF = 3;

   // Width used for compares that must cover every table size
   localparam int WIDE_W = 17;

   // Payload widths
   localparam int KIND_W    = 2;
   localparam int CLUSTER_W = 12;
   localparam int ENTRY_W   = 16;
   localparam int LENGTH_W  = 13;
   localparam int STATUS_W  = 3;

   // FAT16 entry markers
   localparam logic [ENTRY_W-1:0] END_MARK         = 16'hFFFF;
   localparam logic [ENTRY_W-1:0] DATA_CLUSTER_MAX = 16'hFFEF;

   // Request kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_WRITE  = 2'd0,
      KIND_READ   = 2'd1,
      KIND_DEFRAG = 2'd2
   } kind_type;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 3'd0,
      ST_NOTFRAG  = 3'd1,
      ST_NOSPACE  = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_BROKEN   = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_WALK,
      S_SEARCH,
      S_RELOC_RD,
      S_RELOC_ZERO,
      S_RELOC_LINK,
      S_FINISH
   } state_type;

   // Flags returned by the shared link unit
   typedef struct packed {
      logic end_mark;   // data is the end-of-chain mark
      logic zero;       // data is a free entry
      logic in_range;   // data indexes a table entry
      logic is_next;    // data equals position plus one
      logic cnt_hit;    // counter plus one reaches the needed length
      logic cnt_full;   // counter plus one reaches the table size
   } link_flags_type;

endpackage

`default_nettype wire

### rtl/core/fat_chain_defragmenter_core.sv
// Top level of the FAT chain defragmenter: sequencer, table RAM, link unit.
// Depends on fcd_pkg, fcd_ram and fcd_link_unit.
//
// Holds a FAT16 table of TABLE_ENTRIES entries in one single-port RAM and serves one
// request at a time. After reset the table is swept to zero, one entry a cycle, and
// the block takes no request until the sweep is done. A write is done in the idle
// state; a read passes through a state that captures the entry. A defragment walks
// the chain at one link a cycle, scans first-fit at one entry a cycle from entry
// FIRST_SEARCH_CLUSTER up to min(TABLE_ENTRIES, 0xFFF0), then relocates each cluster
// by reading its old link, clearing it and writing the new link, and hands the result
// to the output register once it is free. The single RAM port sets this pacing. A
// finished result waits in the output register while the next request is taken.
`default_nettype none

module fat_chain_defragmenter_core #(
   parameter int TABLE_ENTRIES        = fcd_pkg::TABLE_ENTRIES_DEF,
   parameter int FIRST_SEARCH_CLUSTER = fcd_pkg::FIRST_SEARCH_CLUSTER_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [fcd_pkg::KIND_W-1:0]       req_kind,
   input  wire logic [fcd_pkg::CLUSTER_W-1:0]    req_cluster,
   input  wire logic [fcd_pkg::ENTRY_W-1:0]      req_entry_value,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic      [fcd_pkg::ENTRY_W-1:0]      rsp_read_value,
   output logic      [fcd_pkg::CLUSTER_W-1:0]    rsp_new_first,
   output logic      [fcd_pkg::LENGTH_W-1:0]     rsp_chain_length,
   output logic      [fcd_pkg::STATUS_W-1:0]     rsp_status
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int PW = $clog2(TABLE_ENTRIES + 1);
   localparam int EW = fcd_pkg::ENTRY_W;
   localparam int LW = fcd_pkg::LENGTH_W;
   localparam int CW = fcd_pkg::CLUSTER_W;
   localparam int DATA_LIMIT   = int'(fcd_pkg::DATA_CLUSTER_MAX) + 1;
   localparam int SEARCH_LIMIT = (TABLE_ENTRIES < DATA_LIMIT) ? TABLE_ENTRIES : DATA_LIMIT;
   localparam logic [IW-1:0] LAST_ENTRY = IW'(TABLE_ENTRIES - 1);
   localparam logic [IW-1:0] SEARCH_FROM = IW'(FIRST_SEARCH_CLUSTER);
   localparam logic [PW-1:0] SEARCH_END = PW'(SEARCH_LIMIT);

   // Sequencer and work registers
   fcd_pkg::state_type  state_ff, state_in;
   logic [IW-1:0]       clr_ff, clr_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [PW-1:0]       count_ff, count_in;
   logic                frag_ff, frag_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [PW-1:0]       run_ff, run_in;
   logic [IW-1:0]       start_ff, start_in;
   logic [IW-1:0]       dst_ff, dst_in;
   logic [PW-1:0]       step_ff, step_in;
   logic [EW-1:0]       src_ff, src_in;

   // Pending result
   logic [EW-1:0]       res_read_ff, res_read_in;
   logic [CW-1:0]       res_first_ff, res_first_in;
   logic [LW-1:0]       res_len_ff, res_len_in;
   fcd_pkg::status_type res_status_ff, res_status_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]       rsp_read_value_ff, rsp_read_value_in;
   logic [CW-1:0]       rsp_new_first_ff, rsp_new_first_in;
   logic [LW-1:0]       rsp_chain_length_ff, rsp_chain_length_in;
   logic [fcd_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // RAM port
   logic                ram_we;
   logic [IW-1:0]       ram_addr;
   logic [EW-1:0]       ram_wdata;
   logic [EW-1:0]       ram_rdata;

   // Link unit operands and results
   logic [PW-1:0]       u_pos, u_cnt, u_pos_inc, u_cnt_inc;
   logic [EW-1:0]       u_data;
   fcd_pkg::link_flags_type u_flags;

   fcd_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_ENTRIES),
      .AW    (IW)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   fcd_link_unit #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .PW            (PW)
   ) u_link (
      .pos     (u_pos),
      .cnt     (u_cnt),
      .need    (count_ff),
      .data    (u_data),
      .pos_inc (u_pos_inc),
      .cnt_inc (u_cnt_inc),
      .flags   (u_flags)
   );

   assign req_ready        = (state_ff == fcd_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_new_first    = rsp_new_first_ff;
   assign rsp_chain_length = rsp_chain_length_ff;
   assign rsp_status       = rsp_status_ff;

   // Steer the shared unit's operands by phase
   always_comb begin
      u_pos  = PW'(cur_ff);
      u_cnt  = count_ff;
      u_data = ram_rdata;
      unique case (state_ff) inside
         fcd_pkg::S_IDLE: begin
            u_data = EW'(req_cluster);
         end
         fcd_pkg::S_SEARCH: begin
            u_pos = PW'(scan_ff);
            u_cnt = run_ff;
         end
         fcd_pkg::S_RELOC_RD, fcd_pkg::S_RELOC_ZERO: begin
            u_data = src_ff;
         end
         fcd_pkg::S_RELOC_LINK: begin
            u_pos = PW'(dst_ff);
            u_cnt = step_ff;
         end
         default: begin
         end
      endcase
   end

   // Next state, RAM control and result bookkeeping
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      count_in      = count_ff;
      frag_in       = frag_ff;
      scan_in       = scan_ff;
      run_in        = run_ff;
      start_in      = start_ff;
      dst_in        = dst_ff;
      step_in       = step_ff;
      src_in        = src_ff;
      res_read_in   = res_read_ff;
      res_first_in  = res_first_ff;
      res_len_in    = res_len_ff;
      res_status_in = res_status_ff;

      rsp_valid_in        = rsp_valid_ff & ~rsp_ready;
      rsp_read_value_in   = rsp_read_value_ff;
      rsp_new_first_in    = rsp_new_first_ff;
      rsp_chain_length_in = rsp_chain_length_ff;
      rsp_status_in       = rsp_status_ff;

      ram_we    = 1'b0;
      ram_addr  = IW'(req_cluster);
      ram_wdata = '0;

      unique case (state_ff)
         // Sweep the table to free entries after reset
         fcd_pkg::S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + IW'(1);
            if (clr_ff == LAST_ENTRY) begin
               state_in = fcd_pkg::S_IDLE;
            end
         end

         // Take a beat and dispatch on its kind
         fcd_pkg::S_IDLE: begin
            if (req_valid) begin
               res_read_in   = '0;
               res_first_in  = '0;
               res_len_in    = '0;
               res_status_in = fcd_pkg::ST_DONE;
               src_in        = EW'(req_cluster);
               cur_in        = IW'(req_cluster);
               count_in      = '0;
               frag_in       = 1'b0;
               state_in      = fcd_pkg::S_FINISH;
               unique case (req_kind)
                  fcd_pkg::KIND_WRITE: begin
                     ram_we    = u_flags.in_range;
                     ram_wdata = req_entry_value;
                  end
                  fcd_pkg::KIND_READ: begin
                     if (u_flags.in_range) begin
                        state_in = fcd_pkg::S_READ;
                     end
                  end
                  fcd_pkg::KIND_DEFRAG: begin
                     if (req_cluster == '0) begin
                        res_status_in = fcd_pkg::ST_EMPTY;
                     end else if (!u_flags.in_range) begin
                        res_status_in = fcd_pkg::ST_BROKEN;
                     end else begin
                        state_in = fcd_pkg::S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Capture the entry read
         fcd_pkg::S_READ: begin
            res_read_in = ram_rdata;
            state_in    = fcd_pkg::S_FINISH;
         end

         // Follow the chain one link a cycle, counting and checking contiguity
         fcd_pkg::S_WALK: begin
            if (u_flags.end_mark) begin
               res_len_in = LW'(u_cnt_inc);
               count_in   = u_cnt_inc;
               if (!frag_ff) begin
                  res_status_in = fcd_pkg::ST_NOTFRAG;
                  state_in      = fcd_pkg::S_FINISH;
               end else begin
                  ram_addr = SEARCH_FROM;
                  scan_in  = SEARCH_FROM;
                  run_in   = '0;
                  state_in = fcd_pkg::S_SEARCH;
               end
            end else if (!u_flags.in_range || u_flags.cnt_full) begin
               res_len_in    = LW'(u_cnt_inc);
               res_status_in = fcd_pkg::ST_BROKEN;
               state_in      = fcd_pkg::S_FINISH;
            end else begin
               frag_in  = frag_ff | ~u_flags.is_next;
               cur_in   = IW'(ram_rdata);
               count_in = u_cnt_inc;
               ram_addr = IW'(ram_rdata);
            end
         end

         // First-fit scan for a free run as long as the chain
         fcd_pkg::S_SEARCH: begin
            if (u_flags.zero) begin
               run_in = u_cnt_inc;
               if (run_ff == '0) begin
                  start_in = scan_ff;
               end
            end else begin
               run_in = '0;
            end
            if (u_flags.zero && u_flags.cnt_hit) begin
               dst_in   = (run_ff == '0) ? scan_ff : start_ff;
               step_in  = '0;
               state_in = fcd_pkg::S_RELOC_RD;
            end else if (u_pos_inc == SEARCH_END) begin
               res_status_in = fcd_pkg::ST_NOSPACE;
               state_in      = fcd_pkg::S_FINISH;
            end else begin
               scan_in  = IW'(u_pos_inc);
               ram_addr = IW'(u_pos_inc);
            end
         end

         // Read the old link
         fcd_pkg::S_RELOC_RD: begin
            ram_addr = IW'(src_ff);
            state_in = fcd_pkg::S_RELOC_ZERO;
         end

         // Free the old entry and advance to the next old cluster
         fcd_pkg::S_RELOC_ZERO: begin
            ram_addr = IW'(src_ff);
            if (u_flags.in_range) begin
               ram_we = 1'b1;
               src_in = ram_rdata;
            end else begin
               src_in = '0;
            end
            state_in = fcd_pkg::S_RELOC_LINK;
         end

         // Write the new consecutive link, end mark on the last cluster
         fcd_pkg::S_RELOC_LINK: begin
            ram_we    = 1'b1;
            ram_addr  = dst_ff;
            ram_wdata = u_flags.cnt_hit ? fcd_pkg::END_MARK : EW'(u_pos_inc);
            step_in   = u_cnt_inc;
            dst_in    = IW'(u_pos_inc);
            if (u_flags.cnt_hit) begin
               res_first_in  = CW'(start_ff);
               res_status_in = fcd_pkg::ST_DONE;
               state_in      = fcd_pkg::S_FINISH;
            end else begin
               state_in = fcd_pkg::S_RELOC_RD;
            end
         end

         // Hand the result to the output register once it is free
         fcd_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_read_value_in   = res_read_ff;
               rsp_new_first_in    = res_first_ff;
               rsp_chain_length_in = res_len_ff;
               rsp_status_in       = res_status_ff;
               state_in            = fcd_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = fcd_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fcd_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Work and payload registers
   always_ff @(posedge clock) begin
      cur_ff              <= cur_in;
      count_ff            <= count_in;
      frag_ff             <= frag_in;
      scan_ff             <= scan_in;
      run_ff              <= run_in;
      start_ff            <= start_in;
      dst_ff              <= dst_in;
      step_ff             <= step_in;
      src_ff              <= src_in;
      res_read_ff         <= res_read_in;
      res_first_ff        <= res_first_in;
      res_len_ff          <= res_len_in;
      res_status_ff       <= res_status_in;
      rsp_read_value_ff   <= rsp_read_value_in;
      rsp_new_first_ff    <= rsp_new_first_in;
      rsp_chain_length_ff <= rsp_chain_length_in;
      rsp_status_ff       <= rsp_status_in;
   end

endmodule

`default_nettype wire

### rtl/core/fcd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; instanced for the FAT table.
`default_nettype none

module fcd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write on enable, register the read port every cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end

endmodule

`default_nettype wire

### rtl/core/fcd_link_unit.sv
// Shared increment and compare unit used by the request, walk, search and relocation phases.
// Depends on fcd_pkg for the flag struct and entry constants.
`default_nettype none

module fcd_link_unit #(
   parameter int TABLE_ENTRIES = fcd_pkg::TABLE_ENTRIES_DEF,
   parameter int PW            = $clog2(TABLE_ENTRIES + 1)
) (
   input  wire logic [PW-1:0]                pos,
   input  wire logic [PW-1:0]                cnt,
   input  wire logic [PW-1:0]                need,
   input  wire logic [fcd_pkg::ENTRY_W-1:0]  data,
   output logic      [PW-1:0]                pos_inc,
   output logic      [PW-1:0]                cnt_inc,
   output fcd_pkg::link_flags_type           flags
);

   localparam int WW = fcd_pkg::WIDE_W;
   localparam logic [WW-1:0] TABLE_SIZE = WW'(TABLE_ENTRIES);

   // One position step, one counter step and the compares around them
   always_comb begin
      pos_inc        = pos + PW'(1);
      cnt_inc        = cnt + PW'(1);
      flags.end_mark = (data == fcd_pkg::END_MARK);
      flags.zero     = (data == '0);
      flags.in_range = (WW'(data) < TABLE_SIZE);
      flags.is_next  = (WW'(data) == WW'(pos_inc));
      flags.cnt_hit  = (cnt_inc == need);
      flags.cnt_full = (WW'(cnt_inc) >= TABLE_SIZE);
   end

endmodule

`default_nettype wire
